// ----- hw/rtl/hegq_pkg.sv -----
// ----------------------------------------------------------------------------
// hegq_pkg: shared constants
// Field widths, operation and register codes, and circle constants for the
// heading error / GPS qualifier block.
// ----------------------------------------------------------------------------
package hegq_pkg;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int HEAD_W = 13;
  localparam int CT_W   = 24;
  localparam int AVG_W  = 14;
  localparam int CNT_W  = 6;
  localparam int WIDE_W = 15;

  // running-average divider: numerator and divisor widths
  localparam int NUM_W  = 21;
  localparam int DEN_W  = 5;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [1:0] OP_MEASURE = 2'd0;
  localparam logic [1:0] OP_ACQUIRE = 2'd1;
  localparam logic [1:0] OP_RECORD  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_WINDOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIFT_WINDOW    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIX_HURDLE      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEER_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_LEVEL     = 3'd4;

  localparam logic [1:0] STEER_NONE  = 2'd0;
  localparam logic [1:0] STEER_LEFT  = 2'd1;
  localparam logic [1:0] STEER_RIGHT = 2'd2;

  localparam logic signed [13:0] ERR_HALF = 14'sd2880;
  localparam logic signed [13:0] ERR_FULL = 14'sd5760;

  localparam logic [WIDE_W-1:0] FULL_CIRCLE = 15'd5760;
  localparam logic [WIDE_W-1:0] WRAP_GAP    = 15'd5280;
  localparam logic [WIDE_W-1:0] LOW_SIDE    = 15'd480;

  localparam logic [11:0] ERROR_WINDOW_RST    = 12'd80;
  localparam logic [15:0] DRIFT_WINDOW_RST    = 16'd320;
  localparam logic [4:0]  FIX_HURDLE_RST      = 5'd15;
  localparam logic [15:0] STEER_THRESHOLD_RST = 16'd400;
  localparam logic [15:0] ALARM_LEVEL_RST     = 16'd880;

endpackage

// ----- hw/rtl/heading_error_gps_qualifier_core.sv -----
// ----------------------------------------------------------------------------
// heading_error_gps_qualifier_core: course error tracker with GPS qualifier
// Wraps heading error, keeps a saturating drift, averages GPS headings over
// good fixes and switches to GPS mode after enough of them.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata, s_tuser
//   m_*      out  m_tvalid/m_tready  m_tdata
//   cfg_*    in   cfg_write          cfg_index, cfg_data
//
// Measure request: the result waits on the 21-step serial divider of the
// running average; a measure with a bad fix or a first fix skips the divider,
// and acquire/record and unused codes go from the error step to the finish.
// One request at a time; s_tready is high only when the sequencer is idle.
// The result register frees the input side: a new request is taken while
// the previous result waits for m_tready.
// Synchronous active-high reset restores register defaults and state.
// ----------------------------------------------------------------------------
module heading_error_gps_qualifier_core #(
  parameter int DRIFT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // compass_heading, gps_course, gps_location_valid, cross_track
  input  logic [hegq_pkg::IN_TDATA_W-1:0]   s_tdata,
  // operation
  input  logic [hegq_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // heading_error, drift_total, steer, alarm, gps_mode,
  // qualify_count, target_heading
  output logic [hegq_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_write,
  input  logic [hegq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hegq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hegq_pkg::*;

  localparam int XW = 33;
  localparam logic signed [XW-1:0] DRIFT_HI =
    {{(XW-DRIFT_BITS+1){1'b0}}, {(DRIFT_BITS-1){1'b1}}};
  localparam logic signed [XW-1:0] DRIFT_LO = ~DRIFT_HI;
  localparam logic signed [XW-1:0] SHOW_HI  = 33'sd8388607;
  localparam logic signed [XW-1:0] SHOW_LO  = -33'sd8388608;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_QUAL = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_AVG  = 8'b0010_0000,
    S_GPS  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [11:0] error_window;
  logic [15:0] drift_window;
  logic [4:0]  fix_hurdle;
  logic [15:0] steer_threshold;
  logic [15:0] alarm_level;

  // tracker state
  logic [HEAD_W-1:0]            target;
  logic [HEAD_W-1:0]            recorded_target;
  logic                         recorded_valid;
  logic                         gps_mode_flag;
  logic [CNT_W-1:0]             good_fix_count;
  logic [AVG_W-1:0]             average_heading;
  logic signed [DRIFT_BITS-1:0] drift_sum;
  logic signed [HEAD_W-1:0]     last_error;

  // captured request
  logic [1:0]               op_q;
  logic [HEAD_W-1:0]        compass_q;
  logic [HEAD_W-1:0]        gps_q;
  logic                     valid_q;
  logic signed [CT_W-1:0]   ct_q;

  // work registers
  logic                good_q;
  logic [WIDE_W-1:0]   a_q;
  logic [WIDE_W-1:0]   s_q;
  logic [WIDE_W-1:0]   quot_q;

  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  // divider
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [NUM_W-1:0]   div_quot;
  logic [DEN_W-1:0]   n5;

  // combinational helpers
  logic [HEAD_W-1:0]        heading_sel;
  logic signed [13:0]       diff;
  logic signed [13:0]       wrapped;
  logic signed [XW-1:0]     drift_x;
  logic signed [XW-1:0]     pre_x;
  logic signed [XW-1:0]     sat_x;
  logic signed [13:0]       lerr_x;
  logic signed [13:0]       ew_x;
  logic signed [XW-1:0]     dw_x;
  logic signed [XW-1:0]     st_x;
  logic signed [XW-1:0]     al_x;
  logic signed [XW-1:0]     shown_x;
  logic                     good;
  logic [WIDE_W-1:0]        h15;
  logic [WIDE_W-1:0]        avg15;
  logic [WIDE_W-1:0]        gap;
  logic                     far;
  logic [WIDE_W-1:0]        avg_fold;
  logic [CNT_W-1:0]         count_eff;
  logic [1:0]               steer;
  logic                     alarm;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    heading_sel = gps_mode_flag ? gps_q : compass_q;
    diff = $signed({1'b0, heading_sel}) - $signed({1'b0, target});
    if (diff > ERR_HALF) begin
      wrapped = diff - ERR_FULL;
    end else if (diff < -ERR_HALF) begin
      wrapped = diff + ERR_FULL;
    end else begin
      wrapped = diff;
    end

    drift_x = {{(XW-DRIFT_BITS){drift_sum[DRIFT_BITS-1]}}, drift_sum};
    if (gps_mode_flag) begin
      pre_x = {{(XW-CT_W){ct_q[CT_W-1]}}, ct_q};
    end else begin
      pre_x = drift_x + {{(XW-HEAD_W){wrapped[HEAD_W-1]}}, wrapped[HEAD_W-1:0]};
    end
    if (pre_x > DRIFT_HI) begin
      sat_x = DRIFT_HI;
    end else if (pre_x < DRIFT_LO) begin
      sat_x = DRIFT_LO;
    end else begin
      sat_x = pre_x;
    end

    lerr_x = {last_error[HEAD_W-1], last_error};
    ew_x   = {2'b00, error_window};
    dw_x   = {{(XW-16){1'b0}}, drift_window};
    st_x   = {{(XW-16){1'b0}}, steer_threshold};
    al_x   = {{(XW-16){1'b0}}, alarm_level};
    good = valid_q && (lerr_x < ew_x) && (lerr_x > -ew_x) &&
           (drift_x < dw_x) && (drift_x > -dw_x) && !gps_mode_flag &&
           (good_fix_count <= {1'b0, fix_hurdle});

    h15   = {2'b00, gps_q};
    avg15 = {1'b0, average_heading};
    gap   = (h15 > avg15) ? h15 - avg15 : avg15 - h15;
    far   = gap >= WRAP_GAP;

    n5      = good_fix_count[DEN_W-1:0];
    div_num = NUM_W'(a_q) * NUM_W'(n5 - DEN_W'(1)) + NUM_W'(s_q) + NUM_W'(n5 >> 1);
    div_start = (state == S_MUL);

    avg_fold  = (quot_q >= FULL_CIRCLE) ? quot_q - FULL_CIRCLE : quot_q;
    count_eff = (valid_q && recorded_valid) ? {1'b0, fix_hurdle} + CNT_W'(1)
                                            : good_fix_count;

    if (drift_x > st_x) begin
      steer = STEER_LEFT;
    end else if (drift_x < -st_x) begin
      steer = STEER_RIGHT;
    end else begin
      steer = STEER_NONE;
    end
    alarm = (drift_x >= al_x) || (drift_x <= -al_x);
    if (drift_x > SHOW_HI) begin
      shown_x = SHOW_HI;
    end else if (drift_x < SHOW_LO) begin
      shown_x = SHOW_LO;
    end else begin
      shown_x = drift_x;
    end
  end

  hegq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (n5),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      error_window    <= ERROR_WINDOW_RST;
      drift_window    <= DRIFT_WINDOW_RST;
      fix_hurdle      <= FIX_HURDLE_RST;
      steer_threshold <= STEER_THRESHOLD_RST;
      alarm_level     <= ALARM_LEVEL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ERROR_WINDOW:    error_window    <= cfg_data[11:0];
        CFG_DRIFT_WINDOW:    drift_window    <= cfg_data;
        CFG_FIX_HURDLE:      fix_hurdle      <= cfg_data[4:0];
        CFG_STEER_THRESHOLD: steer_threshold <= cfg_data;
        CFG_ALARM_LEVEL:     alarm_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      target          <= '0;
      recorded_target <= '0;
      recorded_valid  <= 1'b0;
      gps_mode_flag   <= 1'b0;
      good_fix_count  <= CNT_W'(1);
      average_heading <= '0;
      drift_sum       <= '0;
      last_error      <= '0;
    end else begin
      if (out_valid && m_tready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q      <= s_tuser;
            compass_q <= s_tdata[12:0];
            gps_q     <= s_tdata[25:13];
            valid_q   <= s_tdata[26];
            ct_q      <= s_tdata[50:27];
            state     <= S_ERR;
          end
        end
        S_ERR: begin
          case (op_q)
            OP_MEASURE: begin
              last_error <= wrapped[HEAD_W-1:0];
              drift_sum  <= sat_x[DRIFT_BITS-1:0];
              state      <= S_QUAL;
            end
            OP_ACQUIRE: begin
              target         <= compass_q;
              drift_sum      <= '0;
              gps_mode_flag  <= 1'b0;
              good_fix_count <= CNT_W'(1);
              state          <= S_FIN;
            end
            OP_RECORD: begin
              recorded_target <= compass_q;
              recorded_valid  <= 1'b1;
              state           <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_QUAL: begin
          good_q <= good;
          a_q    <= avg15 + ((far && !(h15 < LOW_SIDE)) ? FULL_CIRCLE : '0);
          s_q    <= h15 + ((far && (h15 < LOW_SIDE)) ? FULL_CIRCLE : '0);
          quot_q <= h15;
          if (good && good_fix_count > CNT_W'(1)) begin
            state <= S_MUL;
          end else begin
            state <= S_AVG;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            quot_q <= div_quot[WIDE_W-1:0];
            state  <= S_AVG;
          end
        end
        S_AVG: begin
          if (good_q) begin
            average_heading <= avg_fold[AVG_W-1:0];
            good_fix_count  <= good_fix_count + CNT_W'(1);
          end else begin
            average_heading <= '0;
            good_fix_count  <= CNT_W'(1);
          end
          state <= S_GPS;
        end
        S_GPS: begin
          good_fix_count <= count_eff;
          if (count_eff > {1'b0, fix_hurdle} && !gps_mode_flag) begin
            gps_mode_flag <= 1'b1;
            target <= recorded_valid ? recorded_target : average_heading[HEAD_W-1:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || m_tready) begin
            out_data <= {4'b0000, target, good_fix_count, gps_mode_flag, alarm, steer,
                         shown_x[CT_W-1:0], last_error};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while a request is in flight");

  a_gps_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(gps_mode_flag) |-> good_fix_count > {1'b0, fix_hurdle})
    else $error("gps mode entered without enough good fixes");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    good_fix_count != '0)
    else $error("good fix count reached zero");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_FIN)
    else $error("result raised outside the finish step");

  a_div_handoff: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && div_done |=> state == S_AVG)
    else $error("divider result not taken");

endmodule

// ----- hw/rtl/hegq_div.sv -----
// ----------------------------------------------------------------------------
// hegq_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module hegq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hegq_pkg::NUM_W-1:0]  num,
  input  logic [hegq_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [hegq_pkg::NUM_W-1:0]  quot
);
  import hegq_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [NUM_W-1:0]    acc;
  logic [DEN_W-1:0]    rem;
  logic [DEN_W-1:0]    den_q;
  logic [DEN_W:0]      trial;
  logic                fits;

  always_comb begin
    trial = {rem, acc[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      acc   <= num;
      den_q <= den;
      rem   <= '0;
      step  <= '0;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      acc  <= {acc[NUM_W-2:0], fits};
      step <= step + STEP_W'(1);
      busy <= (step != STEP_W'(NUM_W - 1));
      done <= (step == STEP_W'(NUM_W - 1));
    end else begin
      done <= 1'b0;
    end
  end

  assign quot = acc;

endmodule
